// File: sv/fmprt_pkg.sv
// Shared types, codes and defaults for the first-match packet rule table.
// No dependencies; used by every module of the block.
package fmprt_pkg;

   localparam int DEF_MAX_RULES = 16;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_CHECK  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_BAD_INDEX = 2'd2;

   localparam logic [1:0] VER_ZERO = 2'd0;
   localparam logic [1:0] VER_ONE  = 2'd1;
   localparam logic [1:0] VER_RULE = 2'd2;

   typedef struct packed {
      logic [7:0]  proto;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic        allow;
   } rule_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  proto;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic        rule_permits;
      logic [7:0]  rule_index;
   } req_type;

   typedef struct packed {
      logic       verdict;
      logic [1:0] status;
      logic [4:0] rule_count;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       append;
      logic       ptr_from_index;
      logic       ptr_zero;
      logic       ptr_step;
      logic       read_cur;
      logic       read_next;
      logic       shift_write;
      logic       shrink;
      logic       res_set;
      logic [1:0] res_status;
      logic       ver_set;
      logic [1:0] ver_sel;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       full;
      logic       index_bad;
      logic       empty;
      logic       more;
      logic       hit;
      logic       out_free;
   } sts_type;

endpackage

// File: sv/fmprt_if.sv
// Handshake channels of the rule table: request items in, result items out.
// Plain valid/ready interfaces; no package dependency.
interface fmprt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  proto;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic        rule_permits;
   logic [7:0]  rule_index;

   modport source (output valid, output mode, output proto, output src_addr,
                   output dst_addr, output rule_permits, output rule_index,
                   input ready);
   modport sink   (input valid, input mode, input proto, input src_addr,
                   input dst_addr, input rule_permits, input rule_index,
                   output ready);
endinterface

interface fmprt_rsp_if;
   logic       valid;
   logic       ready;
   logic       verdict;
   logic [1:0] status;
   logic [4:0] rule_count;

   modport source (output valid, output verdict, output status, output rule_count,
                   input ready);
   modport sink   (input valid, input verdict, input status, input rule_count,
                   output ready);
endinterface

// File: sv/first_match_packet_rule_table_unit.sv
// First-match packet rule table, one item at a time: add, bad remove, empty-table check
// and unused mode go from dispatch straight to finish; the next item is taken only after
// the result is loaded out. Good remove moves each later rule up, a read then a write;
// non-empty check scans to the first match (one read port, one rule a pass).
// A result held by the receiver stalls the input. Reset: synchronous; clears rule count,
// controller state and output valid; rule memory contents are left undefined.
module first_match_packet_rule_table_unit #(
   parameter int MAX_RULES = fmprt_pkg::DEF_MAX_RULES
) (
   input  logic clock,
   input  logic reset,
   fmprt_req_if.sink   req_chan,
   fmprt_rsp_if.source rsp_chan
);

   fmprt_pkg::req_type req_data;
   fmprt_pkg::rsp_type rsp_data;
   fmprt_pkg::cmd_type cmd;
   fmprt_pkg::sts_type sts;
   logic               req_ready;
   logic               rsp_valid;

   assign req_data.mode         = req_chan.mode;
   assign req_data.proto        = req_chan.proto;
   assign req_data.src_addr     = req_chan.src_addr;
   assign req_data.dst_addr     = req_chan.dst_addr;
   assign req_data.rule_permits = req_chan.rule_permits;
   assign req_data.rule_index   = req_chan.rule_index;
   assign req_chan.ready        = req_ready;

   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.verdict    = rsp_data.verdict;
   assign rsp_chan.status     = rsp_data.status;
   assign rsp_chan.rule_count = rsp_data.rule_count;

   fmprt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fmprt_dp #(
      .MAX_RULES (MAX_RULES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/fmprt_dp.sv
// Datapath of the rule table: rule memory, rule count, scan pointer,
// captured item, result and output registers. Depends on fmprt_pkg.
module fmprt_dp #(
   parameter int MAX_RULES = fmprt_pkg::DEF_MAX_RULES
) (
   input  logic               clock,
   input  logic               reset,
   input  fmprt_pkg::req_type req_data,
   input  fmprt_pkg::cmd_type cmd,
   output fmprt_pkg::sts_type sts,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fmprt_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_RULES + 1);
   localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

   fmprt_pkg::rule_type rule_mem_ff [MAX_RULES];
   fmprt_pkg::rule_type rd_data_ff;
   fmprt_pkg::req_type  req_ff;
   fmprt_pkg::rsp_type  rsp_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          verdict_ff, verdict_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]       ptr_ext;
   logic [CW-1:0]       ptr_plus;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_addr;
   fmprt_pkg::rule_type wr_rule;
   fmprt_pkg::rule_type new_rule;
   logic                wr_en;
   logic                rd_en;

   assign ptr_ext  = CW'(ptr_ff);
   assign ptr_plus = CW'(ptr_ext + CW'(1));

   assign new_rule.proto    = req_ff.proto;
   assign new_rule.src_addr = req_ff.src_addr;
   assign new_rule.dst_addr = req_ff.dst_addr;
   assign new_rule.allow    = req_ff.rule_permits;

   assign wr_en   = cmd.append | cmd.shift_write;
   assign wr_addr = cmd.append ? AW'(count_ff) : ptr_ff;
   assign wr_rule = cmd.append ? new_rule : rd_data_ff;
   assign rd_en   = cmd.read_cur | cmd.read_next;
   assign rd_addr = cmd.read_next ? AW'(ptr_plus) : ptr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rule_mem_ff[wr_addr] <= wr_rule;
      end
      if (rd_en) begin
         rd_data_ff <= rule_mem_ff[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.append) begin
         count_in = CW'(count_ff + CW'(1));
      end else if (cmd.shrink) begin
         count_in = CW'(count_ff - CW'(1));
      end

      ptr_in = ptr_ff;
      if (cmd.ptr_from_index) begin
         ptr_in = AW'(req_ff.rule_index - 8'd1);
      end else if (cmd.ptr_zero) begin
         ptr_in = '0;
      end else if (cmd.ptr_step) begin
         ptr_in = AW'(ptr_plus);
      end

      verdict_in = verdict_ff;
      status_in  = status_ff;
      if (cmd.res_set) begin
         status_in = cmd.res_status;
      end
      if (cmd.ver_set) begin
         case (cmd.ver_sel)
            fmprt_pkg::VER_ZERO: verdict_in = 1'b0;
            fmprt_pkg::VER_ONE:  verdict_in = 1'b1;
            fmprt_pkg::VER_RULE: verdict_in = rd_data_ff.allow;
            default:             verdict_in = 1'b0;
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      verdict_ff <= verdict_in;
      status_ff  <= status_in;
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.load_out) begin
         rsp_ff.verdict    <= verdict_ff;
         rsp_ff.status     <= status_ff;
         rsp_ff.rule_count <= 5'(count_ff);
      end
   end

   always_comb begin
      sts.mode      = req_ff.mode;
      sts.full      = (count_ff == CW'(MAX_RULES));
      sts.index_bad = (req_ff.rule_index == 8'd0) || (req_ff.rule_index > 8'(count_ff));
      sts.empty     = (count_ff == '0);
      sts.more      = (ptr_plus < count_ff);
      sts.hit       = ((rd_data_ff.proto == 8'd0) || (rd_data_ff.proto == req_ff.proto))
                   && ((rd_data_ff.src_addr == 32'd0)
                       || (rd_data_ff.src_addr == req_ff.src_addr))
                   && ((rd_data_ff.dst_addr == 32'd0)
                       || (rd_data_ff.dst_addr == req_ff.dst_addr));
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/fmprt_ctrl.sv
// Controller of the rule table: sequences add, remove shift and check scan.
// Drives datapath commands from its status. Depends on fmprt_pkg.
module fmprt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fmprt_pkg::sts_type sts,
   output fmprt_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_SHIFT_RD = 3'd2;
   localparam logic [2:0] S_SHIFT_WR = 3'd3;
   localparam logic [2:0] S_CHK_RD   = 3'd4;
   localparam logic [2:0] S_CHK_EV   = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = fmprt_pkg::ST_OK;
            cmd.ver_set    = 1'b1;
            cmd.ver_sel    = fmprt_pkg::VER_ZERO;
            state_in       = S_FINISH;
            case (sts.mode)
               fmprt_pkg::MODE_ADD: begin
                  if (sts.full) begin
                     cmd.res_status = fmprt_pkg::ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               fmprt_pkg::MODE_REMOVE: begin
                  if (sts.index_bad) begin
                     cmd.res_status = fmprt_pkg::ST_BAD_INDEX;
                  end else begin
                     cmd.ptr_from_index = 1'b1;
                     state_in           = S_SHIFT_RD;
                  end
               end
               fmprt_pkg::MODE_CHECK: begin
                  if (sts.empty) begin
                     cmd.ver_sel = fmprt_pkg::VER_ONE;
                  end else begin
                     cmd.ptr_zero = 1'b1;
                     state_in     = S_CHK_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (sts.more) begin
               cmd.read_next = 1'b1;
               state_in      = S_SHIFT_WR;
            end else begin
               cmd.shrink = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_write = 1'b1;
            cmd.ptr_step    = 1'b1;
            state_in        = S_SHIFT_RD;
         end
         S_CHK_RD: begin
            cmd.read_cur = 1'b1;
            state_in     = S_CHK_EV;
         end
         S_CHK_EV: begin
            if (sts.hit) begin
               cmd.ver_set = 1'b1;
               cmd.ver_sel = fmprt_pkg::VER_RULE;
               state_in    = S_FINISH;
            end else if (sts.more) begin
               cmd.ptr_step = 1'b1;
               state_in     = S_CHK_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
